// File: rtl/igsd_pkg.sv
// ----------------------------------------------------------------------------
// igsd_pkg
// Shared types, constants and fp32 helper functions for the group-scaled
// int4 x int8 dot product.
// ----------------------------------------------------------------------------
package igsd_pkg;

    localparam int ACC_W  = 20;
    localparam int PROD_W = 12;
    localparam int MAG_W  = 52;
    localparam int EXP_W  = 13;

    localparam logic [31:0] FP_QNAN = 32'hFFC0_0000;
    localparam logic [31:0] FP_QBIT = 32'h0040_0000;

    typedef struct packed {
        logic                    sign;
        logic [23:0]             man;
        logic signed [EXP_W-1:0] exp;
        logic                    nan;
        logic                    inf;
        logic [31:0]             bits;
    } unp_t;

    function automatic unp_t fp_unpack(input logic [31:0] b);
        unp_t u;
        u.sign = b[31];
        u.bits = b;
        u.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        u.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        if (b[30:23] == 8'd0)
        begin
            u.man = {1'b0, b[22:0]};
            u.exp = -13'sd149;
        end
        else
        begin
            u.man = {1'b1, b[22:0]};
            u.exp = $signed({5'd0, b[30:23]}) - 13'sd150;
        end
        return u;
    endfunction

    // Rounds the value mag * 2^exp (mag has its top bit set, or is zero)
    // to fp32 with round to nearest even, including subnormals and overflow.
    function automatic logic [31:0] fp_round(input logic sign,
                                             input logic [MAG_W-1:0] mag,
                                             input logic signed [EXP_W-1:0] exp);
        logic signed [EXP_W-1:0] lsb_e;
        logic signed [EXP_W-1:0] r_s;
        logic signed [EXP_W-1:0] be;
        logic [8:0]              r;
        logic [MAG_W-1:0]        kept;
        logic [MAG_W-1:0]        gb;
        logic                    g;
        logic                    st;
        logic [24:0]             m;
        lsb_e = exp + 13'sd28;
        if (lsb_e < -13'sd149)
        begin
            lsb_e = -13'sd149;
        end
        r_s  = lsb_e - exp;
        r    = r_s[8:0];
        kept = mag >> r;
        gb   = mag >> (r - 9'd1);
        g    = gb[0];
        st   = ((gb << (r - 9'd1)) != mag);
        m    = kept[24:0] + {24'd0, g & (st | kept[0])};
        if (m[24])
        begin
            m     = m >> 1;
            lsb_e = lsb_e + 13'sd1;
        end
        be = m[23] ? (lsb_e + 13'sd150) : 13'sd0;
        if (be >= 13'sd255)
        begin
            return {sign, 8'hFF, 23'd0};
        end
        return {sign, be[7:0], m[22:0]};
    endfunction

endpackage

// File: rtl/igsd_lane.sv
// ----------------------------------------------------------------------------
// igsd_lane
// One column lane: signed 4-bit weight times signed 8-bit activation.
// ----------------------------------------------------------------------------
module igsd_lane
(
    input  logic [3:0]                         nibble,
    input  logic [7:0]                         act,
    input  logic                               en,
    output logic signed [igsd_pkg::PROD_W-1:0] prod
);

    logic signed [igsd_pkg::PROD_W-1:0] full;

    assign full = $signed({{8{nibble[3]}}, nibble}) * $signed({{4{act[7]}}, act});
    assign prod = en ? full : '0;

endmodule

// File: rtl/igsd_fpu.sv
// ----------------------------------------------------------------------------
// igsd_fpu
// Sequenced fp32 unit: converts the group sum, scales it twice and adds it
// to the row sum, sharing one normalize stage and one rounding stage.
// ----------------------------------------------------------------------------
module igsd_fpu
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [igsd_pkg::ACC_W-1:0] dot,
    input  logic [15:0]                weight_scale,
    input  logic [31:0]                act_scale,
    input  logic [31:0]                row_in,
    output logic                       done,
    output logic [31:0]                result
);

    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_M1   = 4'd1;
    localparam logic [3:0] PH_N1   = 4'd2;
    localparam logic [3:0] PH_R1   = 4'd3;
    localparam logic [3:0] PH_M2   = 4'd4;
    localparam logic [3:0] PH_N2   = 4'd5;
    localparam logic [3:0] PH_R2   = 4'd6;
    localparam logic [3:0] PH_A    = 4'd7;
    localparam logic [3:0] PH_N3   = 4'd8;
    localparam logic [3:0] PH_R3   = 4'd9;
    localparam logic [3:0] PH_DONE = 4'd10;

    logic [3:0]  ph_reg, ph_next;
    logic [igsd_pkg::ACC_W-1:0] dot_reg;
    logic [15:0] ws_reg;
    logic [31:0] as_reg, row_reg, t_reg;

    logic                                 sign_reg, sign_next;
    logic [igsd_pkg::MAG_W-1:0]           mag_reg, mag_next;
    logic signed [igsd_pkg::EXP_W-1:0]    exp_reg, exp_next;
    logic                                 spec_reg, spec_next;
    logic [31:0]                          sval_reg, sval_next;

    igsd_pkg::unp_t ma, mb, aa, ab, big, sm;
    logic [19:0]    dmag;
    logic [47:0]    prod;
    logic [8:0]     d;
    logic [49:0]    big_al, sm_full, sm_sh;
    logic [50:0]    sum;
    logic           sum_sign;
    logic [5:0]     lz;
    logic [31:0]    rnd;

    always_comb
    begin
        dmag          = dot_reg[igsd_pkg::ACC_W-1] ? (~dot_reg + 20'd1) : dot_reg;
        ma            = '0;
        ma.sign       = dot_reg[igsd_pkg::ACC_W-1];
        ma.man        = {4'd0, dmag};
        ma.exp        = '0;
        mb            = igsd_pkg::fp_unpack({ws_reg, 16'd0});
        if (ph_reg == PH_M2)
        begin
            ma = igsd_pkg::fp_unpack(t_reg);
            mb = igsd_pkg::fp_unpack(as_reg);
        end
        prod = ma.man * mb.man;

        aa = igsd_pkg::fp_unpack(row_reg);
        ab = igsd_pkg::fp_unpack(t_reg);
        if (aa.exp >= ab.exp)
        begin
            big = aa;
            sm  = ab;
        end
        else
        begin
            big = ab;
            sm  = aa;
        end
        d       = 9'(big.exp - sm.exp);
        big_al  = {big.man, 26'd0};
        sm_full = {sm.man, 26'd0};
        sm_sh   = sm_full >> d;
        sm_sh[0] = sm_sh[0] | ((sm_sh << d) != sm_full);
        if (big.sign == sm.sign)
        begin
            sum      = {1'b0, big_al} + {1'b0, sm_sh};
            sum_sign = big.sign;
        end
        else if (big_al >= sm_sh)
        begin
            sum      = {1'b0, big_al - sm_sh};
            sum_sign = big.sign;
        end
        else
        begin
            sum      = {1'b0, sm_sh - big_al};
            sum_sign = sm.sign;
        end
        if (sum == 51'd0)
        begin
            sum_sign = aa.sign & ab.sign;
        end

        lz = 6'd0;
        for (int i = 0; i < igsd_pkg::MAG_W; i++)
        begin
            if (mag_reg[i])
            begin
                lz = 6'(igsd_pkg::MAG_W - 1 - i);
            end
        end
        rnd = spec_reg ? sval_reg : igsd_pkg::fp_round(sign_reg, mag_reg, exp_reg);
    end

    always_comb
    begin
        ph_next   = ph_reg;
        sign_next = sign_reg;
        mag_next  = mag_reg;
        exp_next  = exp_reg;
        spec_next = spec_reg;
        sval_next = sval_reg;
        case (ph_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    ph_next = PH_M1;
                end
            end
            PH_M1, PH_M2:
            begin
                sign_next = ma.sign ^ mb.sign;
                mag_next  = {4'd0, prod};
                exp_next  = ma.exp + mb.exp;
                spec_next = 1'b1;
                if (ma.nan)
                begin
                    sval_next = ma.bits | igsd_pkg::FP_QBIT;
                end
                else if (mb.nan)
                begin
                    sval_next = mb.bits | igsd_pkg::FP_QBIT;
                end
                else if ((ma.inf && mb.man == 24'd0) || (mb.inf && ma.man == 24'd0))
                begin
                    sval_next = igsd_pkg::FP_QNAN;
                end
                else if (ma.inf || mb.inf)
                begin
                    sval_next = {ma.sign ^ mb.sign, 8'hFF, 23'd0};
                end
                else
                begin
                    spec_next = 1'b0;
                end
                ph_next = (ph_reg == PH_M1) ? PH_N1 : PH_N2;
            end
            PH_A:
            begin
                sign_next = sum_sign;
                mag_next  = {1'b0, sum};
                exp_next  = big.exp - 13'sd26;
                spec_next = 1'b1;
                if (aa.nan)
                begin
                    sval_next = aa.bits | igsd_pkg::FP_QBIT;
                end
                else if (ab.nan)
                begin
                    sval_next = ab.bits | igsd_pkg::FP_QBIT;
                end
                else if (aa.inf && ab.inf && (aa.sign != ab.sign))
                begin
                    sval_next = igsd_pkg::FP_QNAN;
                end
                else if (aa.inf)
                begin
                    sval_next = aa.bits;
                end
                else if (ab.inf)
                begin
                    sval_next = ab.bits;
                end
                else
                begin
                    spec_next = 1'b0;
                end
                ph_next = PH_N3;
            end
            PH_N1, PH_N2, PH_N3:
            begin
                mag_next = mag_reg << lz;
                exp_next = exp_reg - $signed({7'd0, lz});
                ph_next  = ph_reg + 4'd1;
            end
            PH_R1:
            begin
                ph_next = PH_M2;
            end
            PH_R2:
            begin
                ph_next = PH_A;
            end
            PH_R3:
            begin
                ph_next = PH_DONE;
            end
            PH_DONE:
            begin
                ph_next = PH_IDLE;
            end
            default:
            begin
                ph_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_IDLE;
        end
        else
        begin
            ph_reg <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_reg <= sign_next;
        mag_reg  <= mag_next;
        exp_reg  <= exp_next;
        spec_reg <= spec_next;
        sval_reg <= sval_next;
        if (ph_reg == PH_IDLE && start)
        begin
            dot_reg <= dot;
            ws_reg  <= weight_scale;
            as_reg  <= act_scale;
            row_reg <= row_in;
        end
        if (ph_reg == PH_R1 || ph_reg == PH_R2 || ph_reg == PH_R3)
        begin
            t_reg <= rnd;
        end
    end

    assign done   = (ph_reg == PH_DONE);
    assign result = t_reg;

endmodule

// File: rtl/int4_int8_group_scaled_dot.sv
// ----------------------------------------------------------------------------
// int4_int8_group_scaled_dot
// Streams packed int4 weight pairs against int8 activations, scales each
// group sum in fp32 and emits the fp32 row sum at row end.
// ----------------------------------------------------------------------------
// An item that does not close a group is accumulated without a stall; such items
// transfer back-to-back. An item that closes a group holds s_tready low while the
// shared fp32 sequencer runs (the first multiply also converts the group sum, then
// a second multiply and one add, each normalized and rounded). A row-end item then
// loads the output register, raising valid; a full output register adds stalls.
// Reset clears the group sum, the row sum to +0.0 and the output valid.
module int4_int8_group_scaled_dot
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // weight_pair, act_even, act_odd, weight_scale, act_scale
    input  logic [71:0] s_tdata,
    // odd_present, grp_last
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // row_sum
    output logic [31:0] m_tdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FPU  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]  st_reg, st_next;
    logic [igsd_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [31:0] row_reg, row_next;
    logic        emit_reg, emit_next;
    logic        ov_reg, ov_next;
    logic [31:0] od_reg, od_next;

    logic signed [igsd_pkg::PROD_W-1:0] p_even, p_odd;
    logic [igsd_pkg::ACC_W-1:0] acc_sum;
    logic        acc_in, close, fpu_done;
    logic [31:0] fpu_res;

    igsd_lane u_even
    (
        .nibble (s_tdata[3:0]),
        .act    (s_tdata[15:8]),
        .en     (1'b1),
        .prod   (p_even)
    );

    igsd_lane u_odd
    (
        .nibble (s_tdata[7:4]),
        .act    (s_tdata[23:16]),
        .en     (s_tuser[0]),
        .prod   (p_odd)
    );

    assign s_tready = (st_reg == ST_IDLE);
    assign acc_in   = s_tvalid && s_tready;
    assign close    = s_tuser[1] || s_tlast;
    assign acc_sum  = acc_reg + 20'(p_even) + 20'(p_odd);

    igsd_fpu u_fpu
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (acc_in && close),
        .dot          (acc_sum),
        .weight_scale (s_tdata[39:24]),
        .act_scale    (s_tdata[71:40]),
        .row_in       (row_reg),
        .done         (fpu_done),
        .result       (fpu_res)
    );

    always_comb
    begin
        st_next   = st_reg;
        acc_next  = acc_reg;
        row_next  = row_reg;
        emit_next = emit_reg;
        ov_next   = ov_reg && !m_tready;
        od_next   = od_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (acc_in)
                begin
                    if (close)
                    begin
                        acc_next  = '0;
                        emit_next = s_tlast;
                        st_next   = ST_FPU;
                    end
                    else
                    begin
                        acc_next = acc_sum;
                    end
                end
            end
            ST_FPU:
            begin
                if (fpu_done)
                begin
                    row_next = fpu_res;
                    st_next  = emit_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next  = 1'b1;
                    od_next  = row_reg;
                    row_next = 32'd0;
                    st_next  = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            acc_reg  <= '0;
            row_reg  <= 32'd0;
            emit_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            acc_reg  <= acc_next;
            row_reg  <= row_next;
            emit_reg <= emit_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;

endmodule
